// ===== sv/fbr_pkg.sv =====
package fbr_pkg;

	localparam int DefScreenWidth  = 128;
	localparam int DefScreenHeight = 64;

	// signed pixel coordinate and error term widths
	localparam int CoordW = 10;
	localparam int AccW   = 16;

	localparam logic [2:0] KIND_PIXEL  = 3'd0;
	localparam logic [2:0] KIND_LINE   = 3'd1;
	localparam logic [2:0] KIND_CIRCLE = 3'd2;
	localparam logic [2:0] KIND_FILL   = 3'd3;
	localparam logic [2:0] KIND_READ   = 3'd4;

	localparam logic signed [AccW-1:0] CircleInit  = AccW'(3);
	localparam logic signed [AccW-1:0] CircleIncA  = AccW'(6);
	localparam logic signed [AccW-1:0] CircleIncAB = AccW'(10);

	typedef enum logic [1:0] {
		MODE_CLEAR,
		MODE_SET,
		MODE_XOR,
		MODE_KEEP
	} draw_mode_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WALK,
		ST_RMW,
		ST_READ,
		ST_FILL,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] x_start;
		logic [7:0] y_start;
		logic [7:0] x_end;
		logic [7:0] y_end;
		logic [7:0] radius;
		logic [1:0] draw_mode;
		logic [7:0] fill_byte;
		logic [9:0] byte_address;
	} in_word_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       rejected;
	} out_word_t;

	typedef struct packed {
		logic                     circle;
		logic signed [CoordW-1:0] x0;
		logic signed [CoordW-1:0] y0;
		logic signed [CoordW-1:0] x1;
		logic signed [CoordW-1:0] y1;
		logic [7:0]               radius;
	} walk_cmd_t;

	typedef struct packed {
		logic                     valid;
		logic signed [CoordW-1:0] x;
		logic signed [CoordW-1:0] y;
	} walk_pt_t;

endpackage

// ===== sv/fbr_store.sv =====
module fbr_store #(
	parameter int Depth = fbr_pkg::DefScreenWidth * ((fbr_pkg::DefScreenHeight + 7) / 8)
) (
	input  logic                     clk,
	input  logic                     re,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [7:0]               rdata,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [7:0]               wdata
);

	logic [7:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

`ifndef SYNTHESIS
	a_no_rw_overlap: assert property (@(posedge clk) !(re && we && raddr == waddr))
		else $error("read and write to the same byte in one cycle");
`endif

endmodule

// ===== sv/fbr_walk.sv =====
module fbr_walk (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  fbr_pkg::walk_cmd_t cmd,
	input  logic              step,
	output fbr_pkg::walk_pt_t  pt
);

	localparam int CoordW = fbr_pkg::CoordW;
	localparam int AccW   = fbr_pkg::AccW;

	logic                     busy_q;
	logic                     circle_q;
	logic signed [CoordW-1:0] xa_q, ya_q, xb_q, yb_q;
	logic                     sx_neg_q, sy_neg_q, xmaj_q;
	logic signed [AccW-1:0]   dx2_q, dy2_q, acc_q;
	logic signed [CoordW-1:0] cx_q, cy_q, a_q, b_q;
	logic [2:0]               oct_q;

	logic signed [CoordW-1:0] dx, dy, adx, ady;
	logic signed [AccW-1:0]   dx2, dy2, acc0, rad_ext;
	logic                     xmaj0;

	logic signed [CoordW-1:0] xa_inc, ya_inc, xa_n, ya_n;
	logic signed [AccW-1:0]   acc_n;
	logic                     line_more, acc_ge;

	logic signed [AccW-1:0]   a_ext, b_ext, d_n;
	logic signed [CoordW-1:0] a_n, b_n;
	logic                     circ_more;

	logic signed [CoordW-1:0] cxpa, cxma, cxpb, cxmb, cypa, cyma, cypb, cymb;

	always_comb begin
		dx      = cmd.x1 - cmd.x0;
		dy      = cmd.y1 - cmd.y0;
		adx     = dx[CoordW-1] ? -dx : dx;
		ady     = dy[CoordW-1] ? -dy : dy;
		dx2     = AccW'(adx) <<< 1;
		dy2     = AccW'(ady) <<< 1;
		xmaj0   = dx2 > dy2;
		acc0    = xmaj0 ? (dy2 - AccW'(adx)) : (dx2 - AccW'(ady));
		rad_ext = AccW'({1'b0, cmd.radius});
	end

	always_comb begin
		xa_inc    = sx_neg_q ? xa_q - CoordW'(1) : xa_q + CoordW'(1);
		ya_inc    = sy_neg_q ? ya_q - CoordW'(1) : ya_q + CoordW'(1);
		acc_ge    = !acc_q[AccW-1];
		line_more = xmaj_q ? (xa_q != xb_q) : (ya_q != yb_q);
		if (xmaj_q) begin
			xa_n  = xa_inc;
			ya_n  = acc_ge ? ya_inc : ya_q;
			acc_n = acc_q - (acc_ge ? dx2_q : '0) + dy2_q;
		end else begin
			xa_n  = acc_ge ? xa_inc : xa_q;
			ya_n  = ya_inc;
			acc_n = acc_q - (acc_ge ? dy2_q : '0) + dx2_q;
		end
	end

	always_comb begin
		a_ext = AccW'(a_q);
		b_ext = AccW'(b_q);
		if (acc_q[AccW-1]) begin
			d_n = acc_q + (a_ext <<< 2) + fbr_pkg::CircleIncA;
			b_n = b_q;
		end else begin
			d_n = acc_q + ((a_ext - b_ext) <<< 2) + fbr_pkg::CircleIncAB;
			b_n = b_q - CoordW'(1);
		end
		a_n       = a_q + CoordW'(1);
		circ_more = !(a_n > b_n);
	end

	always_comb begin
		cxpa = cx_q + a_q;
		cxma = cx_q - a_q;
		cxpb = cx_q + b_q;
		cxmb = cx_q - b_q;
		cypa = cy_q + a_q;
		cyma = cy_q - a_q;
		cypb = cy_q + b_q;
		cymb = cy_q - b_q;
		pt.valid = busy_q;
		if (circle_q) begin
			unique case (oct_q)
				3'd0: begin pt.x = cxpa; pt.y = cypb; end
				3'd1: begin pt.x = cxpa; pt.y = cymb; end
				3'd2: begin pt.x = cxma; pt.y = cypb; end
				3'd3: begin pt.x = cxma; pt.y = cymb; end
				3'd4: begin pt.x = cxpb; pt.y = cypa; end
				3'd5: begin pt.x = cxpb; pt.y = cyma; end
				3'd6: begin pt.x = cxmb; pt.y = cypa; end
				default: begin pt.x = cxmb; pt.y = cyma; end
			endcase
		end else begin
			pt.x = xa_q;
			pt.y = ya_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (step && busy_q) begin
			if (circle_q) begin
				if (oct_q == 3'd7 && !circ_more) begin
					busy_q <= 1'b0;
				end
			end else if (!line_more) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			circle_q <= cmd.circle;
			xa_q     <= cmd.x0;
			ya_q     <= cmd.y0;
			xb_q     <= cmd.x1;
			yb_q     <= cmd.y1;
			sx_neg_q <= dx[CoordW-1];
			sy_neg_q <= dy[CoordW-1];
			dx2_q    <= dx2;
			dy2_q    <= dy2;
			xmaj_q   <= xmaj0;
			cx_q     <= cmd.x0;
			cy_q     <= cmd.y0;
			a_q      <= '0;
			b_q      <= CoordW'({1'b0, cmd.radius});
			oct_q    <= '0;
			acc_q    <= cmd.circle ? fbr_pkg::CircleInit - (rad_ext <<< 1) : acc0;
		end else if (step && busy_q) begin
			if (circle_q) begin
				oct_q <= oct_q + 3'd1;
				if (oct_q == 3'd7) begin
					acc_q <= d_n;
					a_q   <= a_n;
					b_q   <= b_n;
				end
			end else if (line_more) begin
				xa_q  <= xa_n;
				ya_q  <= ya_n;
				acc_q <= acc_n;
			end
		end
	end

`ifndef SYNTHESIS
	a_start_gives_point: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> pt.valid)
		else $error("no point after walk start");
`endif

endmodule

// ===== sv/framebuffer_line_circle_raster_core.sv =====
// Monochrome frame store with pixel, line and circle drawing.
// in_valid/in_ready/in_word take one command word; out_valid/out_ready/out_word
// return exactly one result word per command, in order.
// The store is ScreenWidth x ScreenHeight pixels, pages of 8 rows, one byte a
// column, held in one single-port-write, registered-read memory.
// Each drawn pixel is a read-modify-write of its byte; an off-screen circle
// point is stepped over without a memory access. From accept to out_valid:
//   rejected command, draw mode keep, unknown kind, bad read: straight to done
//   pixel: one read-modify-write; read byte: one registered memory read
//   line: one read-modify-write per point along the longest axis
//   circle: 8 points per step, steps ~ 0.71*radius+1
//   fill: every byte of the store written in turn
// After reset the memory is swept to zero, one byte a cycle, and in_ready
// stays low until then.
// One command is processed at a time. The result sits in an output register;
// the next command is taken while it waits, but a finished result waits for
// the output register while out_ready is low.
module framebuffer_line_circle_raster_core #(
	parameter int ScreenWidth  = fbr_pkg::DefScreenWidth,
	parameter int ScreenHeight = fbr_pkg::DefScreenHeight
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  fbr_pkg::in_word_t  in_word,
	output logic              out_valid,
	input  logic              out_ready,
	output fbr_pkg::out_word_t out_word
);

	localparam int PageCount = (ScreenHeight + 7) / 8;
	localparam int Depth     = ScreenWidth * PageCount;
	localparam int AddrW     = $clog2(Depth);
	localparam int CoordW    = fbr_pkg::CoordW;
	localparam logic signed [CoordW-1:0] WidthS   = CoordW'(ScreenWidth);
	localparam logic signed [CoordW-1:0] HeightS  = CoordW'(ScreenHeight);
	localparam logic signed [CoordW-1:0] HeightTop = CoordW'(ScreenHeight - 1);
	localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);

	fbr_pkg::state_t     state_q, state_d;
	fbr_pkg::draw_mode_t mode_q;
	logic [7:0]          fill_q;
	logic [AddrW-1:0]    sweep_q;
	fbr_pkg::out_word_t  res_q, out_q;
	logic                out_valid_q;
	logic [AddrW-1:0]    pix_addr_s1;
	logic [7:0]          pix_bit_s1;

	logic                accept, bad_start, bad_end, pt_on, done_load;
	logic                walk_start, walk_step;
	fbr_pkg::walk_cmd_t  walk_cmd;
	fbr_pkg::walk_pt_t   pt;
	logic [AddrW-1:0]    pt_addr;

	logic                re, we;
	logic [AddrW-1:0]    raddr, waddr;
	logic [7:0]          rdata, wdata, rmw_data;

	assign accept    = in_valid && in_ready;
	assign done_load = (state_q == fbr_pkg::ST_DONE) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	assign bad_start = int'(in_word.x_start) >= ScreenWidth
		|| int'(in_word.y_start) >= ScreenHeight;
	assign bad_end   = int'(in_word.x_end) >= ScreenWidth
		|| int'(in_word.y_end) >= ScreenHeight;

	always_comb begin
		walk_cmd.circle = in_word.kind == fbr_pkg::KIND_CIRCLE;
		walk_cmd.radius = in_word.radius;
		walk_cmd.x0     = CoordW'(in_word.x_start);
		walk_cmd.y0     = CoordW'(in_word.y_start);
		walk_cmd.x1     = CoordW'(in_word.x_start);
		walk_cmd.y1     = CoordW'(in_word.y_start);
		if (in_word.kind == fbr_pkg::KIND_LINE) begin
			walk_cmd.y0 = HeightTop - CoordW'(in_word.y_start);
			walk_cmd.x1 = CoordW'(in_word.x_end);
			walk_cmd.y1 = HeightTop - CoordW'(in_word.y_end);
		end
	end

	assign pt_on   = pt.x >= 0 && pt.x < WidthS && pt.y >= 0 && pt.y < HeightS;
	assign pt_addr = AddrW'((int'(pt.y) >>> 3) * ScreenWidth + int'(pt.x));

	always_comb begin
		unique case (mode_q)
			fbr_pkg::MODE_CLEAR: rmw_data = rdata & ~pix_bit_s1;
			fbr_pkg::MODE_SET:   rmw_data = rdata | pix_bit_s1;
			fbr_pkg::MODE_XOR:   rmw_data = rdata ^ pix_bit_s1;
			default:             rmw_data = rdata;
		endcase
	end

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		walk_start = 1'b0;
		walk_step  = 1'b0;
		re         = 1'b0;
		raddr      = pt_addr;
		we         = 1'b0;
		waddr      = sweep_q;
		wdata      = '0;
		unique case (state_q)
			fbr_pkg::ST_CLEAR: begin
				we = 1'b1;
				if (sweep_q == LastAddr) begin
					state_d = fbr_pkg::ST_IDLE;
				end
			end
			fbr_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					unique case (in_word.kind)
						fbr_pkg::KIND_PIXEL, fbr_pkg::KIND_CIRCLE: begin
							if (bad_start || in_word.draw_mode == fbr_pkg::MODE_KEEP) begin
								state_d = fbr_pkg::ST_DONE;
							end else begin
								walk_start = 1'b1;
								state_d    = fbr_pkg::ST_WALK;
							end
						end
						fbr_pkg::KIND_LINE: begin
							if (bad_start || bad_end
								|| in_word.draw_mode == fbr_pkg::MODE_KEEP) begin
								state_d = fbr_pkg::ST_DONE;
							end else begin
								walk_start = 1'b1;
								state_d    = fbr_pkg::ST_WALK;
							end
						end
						fbr_pkg::KIND_FILL: begin
							state_d = fbr_pkg::ST_FILL;
						end
						fbr_pkg::KIND_READ: begin
							if (int'(in_word.byte_address) < Depth) begin
								re      = 1'b1;
								raddr   = AddrW'(in_word.byte_address);
								state_d = fbr_pkg::ST_READ;
							end else begin
								state_d = fbr_pkg::ST_DONE;
							end
						end
						default: begin
							state_d = fbr_pkg::ST_DONE;
						end
					endcase
				end
			end
			fbr_pkg::ST_WALK: begin
				if (!pt.valid) begin
					state_d = fbr_pkg::ST_DONE;
				end else if (pt_on) begin
					re      = 1'b1;
					state_d = fbr_pkg::ST_RMW;
				end else begin
					walk_step = 1'b1;
				end
			end
			fbr_pkg::ST_RMW: begin
				we        = 1'b1;
				waddr     = pix_addr_s1;
				wdata     = rmw_data;
				walk_step = 1'b1;
				state_d   = fbr_pkg::ST_WALK;
			end
			fbr_pkg::ST_READ: begin
				state_d = fbr_pkg::ST_DONE;
			end
			fbr_pkg::ST_FILL: begin
				we    = 1'b1;
				wdata = fill_q;
				if (sweep_q == LastAddr) begin
					state_d = fbr_pkg::ST_DONE;
				end
			end
			fbr_pkg::ST_DONE: begin
				if (done_load) begin
					state_d = fbr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = fbr_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fbr_pkg::ST_CLEAR;
			sweep_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				sweep_q <= '0;
			end else if (state_q == fbr_pkg::ST_CLEAR || state_q == fbr_pkg::ST_FILL) begin
				sweep_q <= sweep_q + AddrW'(1);
			end
			if (done_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q          <= fbr_pkg::draw_mode_t'(in_word.draw_mode);
			fill_q          <= in_word.fill_byte;
			res_q.read_data <= '0;
			unique case (in_word.kind)
				fbr_pkg::KIND_PIXEL, fbr_pkg::KIND_CIRCLE: res_q.rejected <= bad_start;
				fbr_pkg::KIND_LINE: res_q.rejected <= bad_start || bad_end;
				fbr_pkg::KIND_FILL: res_q.rejected <= 1'b0;
				fbr_pkg::KIND_READ: res_q.rejected <= int'(in_word.byte_address) >= Depth;
				default:            res_q.rejected <= 1'b1;
			endcase
		end
		if (state_q == fbr_pkg::ST_READ) begin
			res_q.read_data <= rdata;
		end
		if (state_q == fbr_pkg::ST_WALK) begin
			pix_addr_s1 <= pt_addr;
			pix_bit_s1  <= 8'h01 << pt.y[2:0];
		end
		if (done_load) begin
			out_q <= res_q;
		end
	end

	fbr_walk u_walk (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (walk_start),
		.cmd    (walk_cmd),
		.step   (walk_step),
		.pt     (pt)
	);

	fbr_store #(
		.Depth (Depth)
	) u_store (
		.clk   (clk),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata)
	);

`ifndef SYNTHESIS
	a_rmw_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == fbr_pkg::ST_RMW |-> $past(state_q == fbr_pkg::ST_WALK))
		else $error("write-back without a preceding read");
	a_onscreen_to_rmw: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == fbr_pkg::ST_WALK && pt.valid && pt_on |=> state_q == fbr_pkg::ST_RMW)
		else $error("on-screen point not written back");
	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == fbr_pkg::ST_DONE))
		else $error("result word without a finished command");
`endif

endmodule

// ===== dv/framebuffer_line_circle_raster_core_test.sv =====
`timescale 1ns / 1ps

module framebuffer_line_circle_raster_core_test;

	localparam int W           = fbr_pkg::DefScreenWidth;
	localparam int H           = fbr_pkg::DefScreenHeight;
	localparam int STORE_BYTES = W * ((H + 7) / 8);
	localparam int IN_BITS     = $bits(fbr_pkg::in_word_t);
	localparam int RANDOM_CMDS = 500;
	localparam int CYCLE_LIMIT = 10_000_000;
	localparam int HOLD_CYCLES = 3000;

	localparam fbr_pkg::out_word_t OK_NONE = '{read_data: 8'h00, rejected: 1'b0};
	localparam fbr_pkg::out_word_t REFUSED = '{read_data: 8'h00, rejected: 1'b1};

	typedef struct {
		fbr_pkg::in_word_t  w;
		bit                 known;
		fbr_pkg::out_word_t want;
	} row_t;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	logic               in_ready;
	fbr_pkg::in_word_t  in_word   = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	fbr_pkg::out_word_t out_word;

	logic [7:0]         pixmap [STORE_BYTES];
	fbr_pkg::out_word_t expected_q [$];
	int                 errors    = 0;
	int                 n_results = 0;
	int                 cycles    = 0;
	bit                 calm_in   = 1'b0;

	framebuffer_line_circle_raster_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_word  (in_word),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_word (out_word)
	);

	always #2 clk = ~clk;

	function automatic void put_pixel(int x, int y, fbr_pkg::draw_mode_t m);
		int         idx;
		logic [7:0] mask;
		if (x < 0 || y < 0 || x >= W || y >= H) return;
		idx  = (y >> 3) * W + x;
		mask = 8'h01 << (y & 7);
		case (m)
			fbr_pkg::MODE_CLEAR: pixmap[idx] = pixmap[idx] & ~mask;
			fbr_pkg::MODE_SET:   pixmap[idx] = pixmap[idx] | mask;
			fbr_pkg::MODE_XOR:   pixmap[idx] = pixmap[idx] ^ mask;
			default: ;
		endcase
	endfunction

	function automatic void trace_line(int xa, int ya, int xb, int yb,
			fbr_pkg::draw_mode_t m);
		int dx, dy, sx, sy, acc;
		dx = xb - xa;
		dy = yb - ya;
		sx = 1;
		sy = 1;
		if (dy < 0) begin
			dy = -dy;
			sy = -1;
		end
		if (dx < 0) begin
			dx = -dx;
			sx = -1;
		end
		dx = dx * 2;
		dy = dy * 2;
		put_pixel(xa, ya, m);
		if (dx > dy) begin
			acc = dy - dx / 2;
			while (xa != xb) begin
				if (acc >= 0) begin
					ya  += sy;
					acc -= dx;
				end
				xa  += sx;
				acc += dy;
				put_pixel(xa, ya, m);
			end
		end else begin
			acc = dx - dy / 2;
			while (ya != yb) begin
				if (acc >= 0) begin
					xa  += sx;
					acc -= dy;
				end
				ya  += sy;
				acc += dx;
				put_pixel(xa, ya, m);
			end
		end
	endfunction

	// eight octant points per step; coincident points are each applied
	function automatic void trace_ring(int cx, int cy, int r, fbr_pkg::draw_mode_t m);
		int a, b, d;
		a = 0;
		b = r;
		d = 3 - 2 * r;
		while (a <= b) begin
			put_pixel(cx + a, cy + b, m);
			put_pixel(cx + a, cy - b, m);
			put_pixel(cx - a, cy + b, m);
			put_pixel(cx - a, cy - b, m);
			put_pixel(cx + b, cy + a, m);
			put_pixel(cx + b, cy - a, m);
			put_pixel(cx - b, cy + a, m);
			put_pixel(cx - b, cy - a, m);
			if (d < 0) begin
				d += 4 * a + 6;
			end else begin
				d += 4 * (a - b) + 10;
				b--;
			end
			a++;
		end
	endfunction

	function automatic fbr_pkg::out_word_t apply_cmd(fbr_pkg::in_word_t w);
		fbr_pkg::out_word_t  r;
		int                  xs, ys, xe, ye;
		fbr_pkg::draw_mode_t m;
		r  = OK_NONE;
		xs = int'(w.x_start);
		ys = int'(w.y_start);
		xe = int'(w.x_end);
		ye = int'(w.y_end);
		m  = fbr_pkg::draw_mode_t'(w.draw_mode);
		case (w.kind)
			fbr_pkg::KIND_PIXEL: begin
				if (xs >= W || ys >= H) r.rejected = 1'b1;
				else put_pixel(xs, ys, m);
			end
			fbr_pkg::KIND_LINE: begin
				if (xs >= W || xe >= W || ys >= H || ye >= H) r.rejected = 1'b1;
				else trace_line(xs, H - 1 - ys, xe, H - 1 - ye, m);
			end
			fbr_pkg::KIND_CIRCLE: begin
				if (xs >= W || ys >= H) r.rejected = 1'b1;
				else trace_ring(xs, ys, int'(w.radius), m);
			end
			fbr_pkg::KIND_FILL: begin
				foreach (pixmap[i]) pixmap[i] = w.fill_byte;
			end
			fbr_pkg::KIND_READ: begin
				if (int'(w.byte_address) < STORE_BYTES) r.read_data = pixmap[w.byte_address];
				else r.rejected = 1'b1;
			end
			default: r.rejected = 1'b1;
		endcase
		return r;
	endfunction

	function automatic fbr_pkg::in_word_t cmd(logic [2:0] kind, int xs, int ys, int xe,
			int ye, int rad, fbr_pkg::draw_mode_t m, int fb, int addr);
		fbr_pkg::in_word_t w;
		w.kind         = kind;
		w.x_start      = 8'(xs);
		w.y_start      = 8'(ys);
		w.x_end        = 8'(xe);
		w.y_end        = 8'(ye);
		w.radius       = 8'(rad);
		w.draw_mode    = m;
		w.fill_byte    = 8'(fb);
		w.byte_address = 10'(addr);
		return w;
	endfunction

	function automatic fbr_pkg::in_word_t random_cmd();
		fbr_pkg::in_word_t w;
		int                pick;
		w    = IN_BITS'({$urandom, $urandom});
		pick = $urandom_range(99);
		if (pick < 20) w.kind = fbr_pkg::KIND_PIXEL;
		else if (pick < 45) w.kind = fbr_pkg::KIND_LINE;
		else if (pick < 63) w.kind = fbr_pkg::KIND_CIRCLE;
		else if (pick < 65) w.kind = fbr_pkg::KIND_FILL;
		else if (pick < 94) w.kind = fbr_pkg::KIND_READ;
		else w.kind = fbr_pkg::KIND_READ + 3'($urandom_range(1, 3));
		// mostly on-screen coordinates, the rest full range
		if ($urandom_range(9) != 0) begin
			w.x_start = 8'($urandom_range(W - 1));
			w.y_start = 8'($urandom_range(H - 1));
			w.x_end   = 8'($urandom_range(W - 1));
			w.y_end   = 8'($urandom_range(H - 1));
		end
		if ($urandom_range(9) != 0) w.radius = 8'($urandom_range(40));
		return w;
	endfunction

	task automatic offer(input fbr_pkg::in_word_t w, input bit known,
			input fbr_pkg::out_word_t want);
		fbr_pkg::out_word_t pred;
		while (!calm_in && $urandom_range(99) < 35) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_word  <= w;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		pred = apply_cmd(w);
		expected_q.push_back(known ? want : pred);
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("framebuffer_line_circle_raster_core regression: fail");
			$finish;
		end
	end

	always @(posedge clk) begin : check_results
		fbr_pkg::out_word_t want;
		if (arst_n && out_valid && out_ready) begin
			n_results <= n_results + 1;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected word, expected none, actual %h", $time, out_word);
				errors++;
			end else begin
				want = expected_q.pop_front();
				if (out_word.read_data !== want.read_data) begin
					$display("%0t: read_data expected %h actual %h",
						$time, want.read_data, out_word.read_data);
					errors++;
				end
				if (out_word.rejected !== want.rejected) begin
					$display("%0t: rejected expected %b actual %b",
						$time, want.rejected, out_word.rejected);
					errors++;
				end
			end
		end
	end

	initial begin : result_side
		int hold;
		bit held;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (!held && n_results >= 80) begin
				held = 1'b1;
				out_ready <= 1'b0;
				for (hold = 0; hold < HOLD_CYCLES; hold++) @(posedge clk);
			end else if (n_results >= 170 && n_results < 280) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(99) >= 35);
			end
		end
	end

	initial begin : command_side
		row_t plan [$];
		foreach (pixmap[i]) pixmap[i] = '0;

		plan.push_back('{cmd(fbr_pkg::KIND_READ, 0, 0, 0, 0, 0, fbr_pkg::MODE_SET, 0, 0),
			1'b1, OK_NONE});
		plan.push_back('{cmd(fbr_pkg::KIND_READ, 0, 0, 0, 0, 0, fbr_pkg::MODE_SET, 0, 1023),
			1'b1, OK_NONE});
		plan.push_back('{cmd(fbr_pkg::KIND_PIXEL, 0, 0, 0, 0, 0, fbr_pkg::MODE_SET, 0, 0),
			1'b1, OK_NONE});
		plan.push_back('{cmd(fbr_pkg::KIND_PIXEL, 127, 63, 0, 0, 0, fbr_pkg::MODE_SET, 0, 0),
			1'b1, OK_NONE});
		plan.push_back('{cmd(fbr_pkg::KIND_READ, 0, 0, 0, 0, 0, fbr_pkg::MODE_SET, 0, 0),
			1'b1, '{8'h01, 1'b0}});
		plan.push_back('{cmd(fbr_pkg::KIND_READ, 0, 0, 0, 0, 0, fbr_pkg::MODE_SET, 0, 1023),
			1'b1, '{8'h80, 1'b0}});
		plan.push_back('{cmd(fbr_pkg::KIND_PIXEL, 128, 63, 0, 0, 0, fbr_pkg::MODE_SET, 0, 0),
			1'b1, REFUSED});
		plan.push_back('{cmd(fbr_pkg::KIND_PIXEL, 127, 64, 0, 0, 0, fbr_pkg::MODE_KEEP, 0, 0),
			1'b1, REFUSED});
		plan.push_back('{cmd(fbr_pkg::KIND_PIXEL, 0, 0, 0, 0, 0, fbr_pkg::MODE_XOR, 0, 0),
			1'b1, OK_NONE});
		plan.push_back('{cmd(fbr_pkg::KIND_READ, 0, 0, 0, 0, 0, fbr_pkg::MODE_SET, 0, 0),
			1'b1, OK_NONE});
		plan.push_back('{cmd(fbr_pkg::KIND_LINE, 0, 0, 127, 63, 0, fbr_pkg::MODE_SET, 0, 0),
			1'b1, OK_NONE});
		plan.push_back('{cmd(fbr_pkg::KIND_READ, 0, 0, 0, 0, 0, fbr_pkg::MODE_SET, 0, 896),
			1'b0, OK_NONE});
		plan.push_back('{cmd(fbr_pkg::KIND_LINE, 128, 0, 0, 0, 0, fbr_pkg::MODE_SET, 0, 0),
			1'b1, REFUSED});
		plan.push_back('{cmd(fbr_pkg::KIND_LINE, 0, 0, 0, 255, 0, fbr_pkg::MODE_XOR, 0, 0),
			1'b1, REFUSED});
		plan.push_back('{cmd(fbr_pkg::KIND_LINE, 3, 20, 100, 25, 0, fbr_pkg::MODE_XOR, 0, 0),
			1'b1, OK_NONE});
		plan.push_back('{cmd(fbr_pkg::KIND_LINE, 50, 0, 40, 63, 0, fbr_pkg::MODE_KEEP, 0, 0),
			1'b1, OK_NONE});
		plan.push_back('{cmd(fbr_pkg::KIND_READ, 0, 0, 0, 0, 0, fbr_pkg::MODE_SET, 0, 700),
			1'b0, OK_NONE});
		plan.push_back('{cmd(fbr_pkg::KIND_CIRCLE, 64, 32, 0, 0, 0, fbr_pkg::MODE_XOR, 0, 0),
			1'b1, OK_NONE});
		plan.push_back('{cmd(fbr_pkg::KIND_READ, 0, 0, 0, 0, 0, fbr_pkg::MODE_SET, 0, 576),
			1'b0, OK_NONE});
		plan.push_back('{cmd(fbr_pkg::KIND_CIRCLE, 0, 0, 0, 0, 255, fbr_pkg::MODE_SET, 0, 0),
			1'b1, OK_NONE});
		plan.push_back('{cmd(fbr_pkg::KIND_CIRCLE, 128, 10, 0, 0, 5, fbr_pkg::MODE_SET, 0, 0),
			1'b1, REFUSED});
		plan.push_back('{cmd(fbr_pkg::KIND_FILL, 0, 0, 0, 0, 0, fbr_pkg::MODE_SET, 255, 0),
			1'b1, OK_NONE});
		plan.push_back('{cmd(fbr_pkg::KIND_READ, 0, 0, 0, 0, 0, fbr_pkg::MODE_SET, 0, 517),
			1'b1, '{8'hff, 1'b0}});
		plan.push_back('{cmd(fbr_pkg::KIND_READ + 3'd1, 0, 0, 0, 0, 0, fbr_pkg::MODE_SET, 0, 0),
			1'b1, REFUSED});
		plan.push_back('{cmd(fbr_pkg::KIND_READ + 3'd3, 0, 0, 0, 0, 0, fbr_pkg::MODE_SET, 0, 0),
			1'b1, REFUSED});
		plan.push_back('{cmd(fbr_pkg::KIND_FILL, 0, 0, 0, 0, 0, fbr_pkg::MODE_SET, 0, 0),
			1'b1, OK_NONE});

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) offer(plan[i].w, plan[i].known, plan[i].want);
		for (int i = 0; i < RANDOM_CMDS; i++) begin
			calm_in = (i >= 150 && i < 250);
			offer(random_cmd(), 1'b0, OK_NONE);
		end
		in_valid <= 1'b0;

		while (expected_q.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0) begin
			$display("framebuffer_line_circle_raster_core regression: pass");
		end else begin
			$display("framebuffer_line_circle_raster_core regression: fail");
		end
		$finish;
	end

endmodule
